// ----- rtl/lbpd_pkg.sv -----
// lbpd_pkg: shared types, codes and helpers of the lossless bitmap pixel decoder
// no dependencies
`timescale 1ns / 1ps

package lbpd_pkg;

	// defaults for the top level parameters
	localparam int MAX_DIMENSION_DEF = 8192;
	localparam int TABLE_DEPTH_DEF   = 256;

	// pixel format codes
	localparam logic [2:0] MODE_PAL_RGB  = 3'd0;
	localparam logic [2:0] MODE_PAL_RGBA = 3'd1;
	localparam logic [2:0] MODE_RGB15    = 3'd2;
	localparam logic [2:0] MODE_XRGB32   = 3'd3;
	localparam logic [2:0] MODE_ARGB32   = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_FORMAT  = 3'd0;
	localparam logic [2:0] REG_ENTRIES = 3'd1;
	localparam logic [2:0] REG_WIDTH   = 3'd2;
	localparam logic [2:0] REG_HEIGHT  = 3'd3;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_PUT
	} state_t;

	// divider request and response
	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [7:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quotient;
	} div_rsp_t;

	// 5-bit colour field scaled to 8 bits
	// c*255/31 is 8c plus floor(7c/31), the small quotient by reciprocal multiply
	function automatic logic [7:0] scale5(input logic [4:0] c);
		logic [7:0]  t;
		logic [15:0] p;
		t = 8'(c) * 8'd7;
		p = 16'(t) * 16'd265;
		return {c, 3'b000} + 8'(p[15:13]);
	endfunction

endpackage

// ----- rtl/lossless_bitmap_pixel_decoder.sv -----
// lossless_bitmap_pixel_decoder: byte stream to rgba pixels with palette and unpremultiply
// depends on lbpd_pkg, lbpd_table, lbpd_div
//
//  channel   direction  signals
//  input     in         in_valid, in_ready, raw_byte
//  output    out        out_valid, out_ready, red, green, blue, alpha, row_end, image_end
//  config    in         cfg_we, cfg_index, cfg_data
//
// bytes that only fill a table entry, a partial pixel or row padding are taken without a stall.
// a byte that completes a pixel passes through the put state (and the look state in palette
// modes, for the table read), and argb32 pixels with partial alpha go through the shared serial divider.
// the block takes no byte while a pixel waits for the output register to free.
// reset needs no clearing pass; the table is only read after it has been loaded.
`timescale 1ns / 1ps

module lossless_bitmap_pixel_decoder
	import lbpd_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
	parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  raw_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        row_end,
	output logic        image_end
);

	localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
	localparam int ROWB_W = DIM_W + 2;
	localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	// configuration registers
	logic [2:0]  pixel_format_q;
	logic [8:0]  palette_entries_q;
	logic [13:0] image_width_q;
	logic [13:0] image_height_q;

	// decode state
	state_t              state_q, state_d;
	logic                loading_q, loading_d;
	logic [CNT_W-1:0]    fill_q, fill_d;
	logic [1:0]          big_q, big_d;
	logic [23:0]         part_q, part_d;
	logic [ROWB_W-1:0]   rowb_q, rowb_d;
	logic [DIM_W-1:0]    col_q, col_d;
	logic [DIM_W-1:0]    row_q, row_d;

	// pending pixel
	logic [7:0] px_r_q, px_g_q, px_b_q, px_a_q;
	logic       px_row_end_q, px_img_end_q, px_idx_ok_q;
	logic [1:0] comp_q;

	logic [2:0]          mode;
	logic [CNT_W-1:0]    entries;
	logic [DIM_W-1:0]    width, height;
	logic [ROWB_W-1:0]   data_bytes, padded;
	logic [ROWB_W:0]     padded_w;
	logic [2:0]          bpp;
	logic                accept, emit, last_col, tbl_we, tbl_re;
	logic [31:0]         entry, rdata;
	logic [AW-1:0]       waddr;
	logic [7:0]          div_c, div_clamped;
	logic                restart_mode_pal;
	logic [2:0]          fmt_new;
	div_req_t            div_req;
	div_rsp_t            div_rsp;
	logic                out_free;

	// effective mode and clamped sizes
	always_comb begin
		logic [16:0] w, h;
		logic [9:0]  pe;
		mode = (pixel_format_q > MODE_ARGB32) ? MODE_XRGB32 : pixel_format_q;
		pe = {1'b0, palette_entries_q};
		if (pe == 10'd0) entries = CNT_W'(1);
		else if (pe > 10'(TABLE_DEPTH)) entries = CNT_W'(TABLE_DEPTH);
		else entries = CNT_W'(pe);
		w = 17'(image_width_q);
		h = 17'(image_height_q);
		if (w == 17'd0) width = DIM_W'(1);
		else if (w > 17'(MAX_DIMENSION)) width = DIM_W'(MAX_DIMENSION);
		else width = DIM_W'(w);
		if (h == 17'd0) height = DIM_W'(1);
		else if (h > 17'(MAX_DIMENSION)) height = DIM_W'(MAX_DIMENSION);
		else height = DIM_W'(h);
	end

	// bytes per pixel and row lengths
	always_comb begin
		unique case (mode) inside
			MODE_PAL_RGB, MODE_PAL_RGBA: bpp = 3'd1;
			MODE_RGB15:                  bpp = 3'd2;
			default:                     bpp = 3'd4;
		endcase
		data_bytes = ROWB_W'(width) * ROWB_W'(bpp);
		padded_w   = (ROWB_W + 1)'(data_bytes) + (ROWB_W + 1)'(3);
		padded     = ROWB_W'(padded_w & ~(ROWB_W + 1)'(3));
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign last_col = (DIM_W + 1)'(col_q) + (DIM_W + 1)'(1) >= (DIM_W + 1)'(width);

	// byte step: counters, table load, pixel completion
	always_comb begin
		loading_d = loading_q;
		fill_d    = fill_q;
		big_d     = big_q;
		part_d    = part_q;
		rowb_d    = rowb_q;
		col_d     = col_q;
		row_d     = row_q;
		emit      = 1'b0;
		tbl_we    = 1'b0;
		entry     = (mode == MODE_PAL_RGBA) ? {part_q, raw_byte}
		                                     : {part_q[15:0], raw_byte, 8'hff};
		waddr     = AW'(fill_q);
		if (loading_q) begin
			if (3'(big_q) + 3'd1 < ((mode == MODE_PAL_RGBA) ? 3'd4 : 3'd3)) begin
				part_d = {part_q[15:0], raw_byte};
				big_d  = big_q + 2'd1;
			end else begin
				tbl_we = 1'b1;
				fill_d = fill_q + CNT_W'(1);
				big_d  = '0;
				part_d = '0;
				if (fill_q + CNT_W'(1) >= entries) loading_d = 1'b0;
			end
		end else begin
			if (rowb_q < data_bytes) begin
				if (3'(big_q) + 3'd1 < bpp) begin
					part_d = {part_q[15:0], raw_byte};
					big_d  = big_q + 2'd1;
				end else begin
					emit   = 1'b1;
					big_d  = '0;
					part_d = '0;
					if (!last_col) col_d = col_q + DIM_W'(1);
				end
			end
			rowb_d = rowb_q + ROWB_W'(1);
			if (rowb_q + ROWB_W'(1) >= padded) begin
				rowb_d = '0;
				col_d  = '0;
				big_d  = '0;
				part_d = '0;
				if ((DIM_W + 1)'(row_q) + (DIM_W + 1)'(1) >= (DIM_W + 1)'(height)) begin
					loading_d = (mode == MODE_PAL_RGB) || (mode == MODE_PAL_RGBA);
					fill_d    = '0;
					row_d     = '0;
				end else begin
					row_d = row_q + DIM_W'(1);
				end
			end
		end
	end

	// restart mode after a configuration write
	assign fmt_new = (cfg_we && cfg_index == REG_FORMAT) ? cfg_data[2:0] : pixel_format_q;
	assign restart_mode_pal = (fmt_new == MODE_PAL_RGB) || (fmt_new == MODE_PAL_RGBA);

	// configuration and byte-level state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q    <= MODE_PAL_RGB;
			palette_entries_q <= 9'd256;
			image_width_q     <= 14'd1;
			image_height_q    <= 14'd1;
			loading_q         <= 1'b1;
			fill_q            <= '0;
			big_q             <= '0;
			part_q            <= '0;
			rowb_q            <= '0;
			col_q             <= '0;
			row_q             <= '0;
		end else if (cfg_we && cfg_index <= REG_HEIGHT) begin
			unique case (cfg_index)
				REG_FORMAT:  pixel_format_q    <= cfg_data[2:0];
				REG_ENTRIES: palette_entries_q <= cfg_data[8:0];
				REG_WIDTH:   image_width_q     <= cfg_data;
				REG_HEIGHT:  image_height_q    <= cfg_data;
				default:     ;
			endcase
			loading_q <= restart_mode_pal;
			fill_q    <= '0;
			big_q     <= '0;
			part_q    <= '0;
			rowb_q    <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (accept) begin
			loading_q <= loading_d;
			fill_q    <= fill_d;
			big_q     <= big_d;
			part_q    <= part_d;
			rowb_q    <= rowb_d;
			col_q     <= col_d;
			row_q     <= row_d;
		end
	end

	// colour table; loading ends before any read, so no forwarding is needed
	assign tbl_re = accept && emit && ((mode == MODE_PAL_RGB) || (mode == MODE_PAL_RGBA));

	lbpd_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (accept && tbl_we),
		.waddr(waddr),
		.wdata(entry),
		.re   (tbl_re),
		.raddr(AW'(raw_byte)),
		.rdata(rdata)
	);

	// serial divider for unpremultiply
	always_comb begin
		case (comp_q)
			2'd0:    div_c = px_r_q;
			2'd1:    div_c = px_g_q;
			default: div_c = px_b_q;
		endcase
		div_req.start    = (state_q == ST_DIV_GO);
		div_req.dividend = {div_c, 8'h00} - 16'(div_c);
		div_req.divisor  = px_a_q;
		div_clamped      = (div_rsp.quotient > 16'd255) ? 8'hff : div_rsp.quotient[7:0];
	end

	lbpd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign out_free = !out_valid || out_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && emit) begin
					unique case (mode) inside
						MODE_PAL_RGB, MODE_PAL_RGBA: state_d = ST_LOOK;
						MODE_ARGB32: begin
							if (part_q[23:16] == 8'h00 || part_q[23:16] == 8'hff)
								state_d = ST_PUT;
							else
								state_d = ST_DIV_GO;
						end
						default: state_d = ST_PUT;
					endcase
				end
			end
			ST_LOOK:     state_d = ST_PUT;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_rsp.done) state_d = (comp_q == 2'd2) ? ST_PUT : ST_DIV_GO;
			end
			ST_PUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// pending pixel datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && emit) begin
			px_row_end_q <= last_col;
			px_img_end_q <= last_col &&
				((DIM_W + 1)'(row_q) + (DIM_W + 1)'(1) >= (DIM_W + 1)'(height));
			px_idx_ok_q  <= CNT_W'(raw_byte) < entries && 9'(raw_byte) < 9'(TABLE_DEPTH);
			comp_q       <= 2'd0;
			if (mode == MODE_RGB15) begin
				px_r_q <= scale5(part_q[6:2]);
				px_g_q <= scale5({part_q[1:0], raw_byte[7:5]});
				px_b_q <= scale5(raw_byte[4:0]);
				px_a_q <= 8'hff;
			end else begin
				px_r_q <= part_q[15:8];
				px_g_q <= part_q[7:0];
				px_b_q <= raw_byte;
				px_a_q <= (mode == MODE_ARGB32) ? part_q[23:16] : 8'hff;
			end
		end else if (state_q == ST_LOOK) begin
			px_r_q <= px_idx_ok_q ? rdata[31:24] : 8'h00;
			px_g_q <= px_idx_ok_q ? rdata[23:16] : 8'h00;
			px_b_q <= px_idx_ok_q ? rdata[15:8]  : 8'h00;
			px_a_q <= px_idx_ok_q ? rdata[7:0]   : 8'h00;
		end else if (state_q == ST_DIV_WAIT && div_rsp.done) begin
			case (comp_q)
				2'd0:    px_r_q <= div_clamped;
				2'd1:    px_g_q <= div_clamped;
				default: px_b_q <= div_clamped;
			endcase
			comp_q <= comp_q + 2'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_PUT && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUT && out_free) begin
			red       <= px_r_q;
			green     <= px_g_q;
			blue      <= px_b_q;
			alpha     <= px_a_q;
			row_end   <= px_row_end_q;
			image_end <= px_img_end_q;
		end
	end

	// checks
	a_no_read_while_loading: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_re |-> !loading_q)
		else $error("colour table read while loading");

	a_divisor_partial: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (div_req.divisor != 8'h00 && div_req.divisor != 8'hff))
		else $error("divider started with trivial alpha");

	a_image_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!image_end || row_end))
		else $error("image end without row end");

endmodule

// ----- rtl/lbpd_table.sv -----
// lbpd_table: colour table memory, one write and one registered read port
// depends on lbpd_pkg
`timescale 1ns / 1ps

module lbpd_table
	import lbpd_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [TABLE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/lbpd_div.sv -----
// lbpd_div: restoring divider, 16-bit dividend by 8-bit divisor, one bit per cycle
// depends on lbpd_pkg
`timescale 1ns / 1ps

module lbpd_div
	import lbpd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [7:0]  rem_q;
	logic [15:0] quo_q;
	logic [7:0]  dsr_q;
	logic [8:0]  trial;
	logic        fits;

	// trial subtraction
	assign trial = {rem_q, quo_q[15]};
	assign fits  = trial >= {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 8'(trial - {1'b0, dsr_q}) : trial[7:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
